@@ hw/rtl/tfpc_pkg.sv @@
// Shared types, constants and a helper function of the thermal fan PID controller.
`timescale 1ns / 1ps

package tfpc_pkg;

    // Fixed field widths
    localparam int TEMP_W = 8;
    localparam int GAIN_W = 16;
    localparam int ERR_W  = 9;
    localparam int PCT_W  = 7;
    localparam int TACH_W = 12;
    localparam int MOD_W  = 6;
    localparam int PROD_W = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMM_TARGET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AMB_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AMB_HIGH    = 3'd7;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP   = 16'd1843;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG  = 16'hFFBA;  // -70
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV  = 16'd1229;
    localparam logic [TEMP_W-1:0] RST_CPU_TARGET  = 8'd80;
    localparam logic [TEMP_W-1:0] RST_DIMM_TARGET = 8'd75;
    localparam logic [TEMP_W-1:0] RST_WARN_LIMIT  = 8'd85;
    localparam logic [TEMP_W-1:0] RST_AMB_LOW     = 8'd20;
    localparam logic [TEMP_W-1:0] RST_AMB_HIGH    = 8'd38;

    // Percent limits
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0] PCT_OPEN_MIN = 7'd40;
    localparam logic [PCT_W-1:0] PCT_BLUE_MIN = 7'd30;

    // PWM and LED bytes
    localparam logic [7:0] PWM_FULL  = 8'd255;
    localparam logic [7:0] LED_OFF   = 8'hFF;
    localparam logic [7:0] LED_BLUE0 = 8'hAA;
    localparam logic [7:0] LED_BLUE1 = 8'h55;
    localparam logic [7:0] LED_RED0  = 8'h55;
    localparam logic [7:0] LED_RED1  = 8'hAA;

    // Tachometers in use and their mask
    localparam int TACH_COUNT = 12;
    localparam logic [TACH_W-1:0] TACH_MASK =
        TACH_W'((13'd1 << TACH_COUNT) - 13'd1);

    // PID term selected for the shared multiplier
    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    typedef struct packed {
        logic       load;      // capture input beat, clear accumulators
        logic       rd;        // read error memory at ring position
        logic       sum_upd;   // update window sums, write new errors
        logic       mul_en;    // issue one product
        logic       mul_dimm;  // product belongs to the DIMM channel
        logic [1:0] mul_term;  // which PID term
        logic       spd;       // register both channel percents
        logic       fan;       // update fan percent and PID history
        logic       out_load;  // load output register
    } t_cmd;

    typedef struct packed {
        logic pid_run;   // power on with valid CPU and ambient readings
        logic out_free;  // output register can take a result this cycle
    } t_status;

    // percent * 255 / 100, divide done as multiply by 2^19/100 rounded up
    function automatic logic [7:0] pct_to_pwm(input logic [PCT_W-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = {pct, 8'b0} - {8'b0, pct};
        prod   = 28'(scaled) * 28'd5243;
        return prod[26:19];
    endfunction

endpackage

@@ hw/rtl/tfpc_ctrl.sv @@
// Sequencer of the thermal fan controller: steps the datapath through one period.
`timescale 1ns / 1ps

module tfpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tfpc_pkg::t_status i_status,
    output tfpc_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_SPD   = 8'b0010_0000,
        S_FAN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_term, n_term;
    logic       r_dimm, n_dimm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= tfpc_pkg::TERM_P;
            r_dimm  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_dimm  <= n_dimm;
        end
    end

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_dimm  = r_dimm;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_status.pid_run ? S_SUM : S_OUT;
            end
            S_SUM: begin
                o_cmd.sum_upd = 1'b1;
                n_term        = tfpc_pkg::TERM_P;
                n_dimm        = 1'b0;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_dimm = r_dimm;
                o_cmd.mul_term = r_term;
                case (r_term)
                    tfpc_pkg::TERM_P: n_term = tfpc_pkg::TERM_I;
                    tfpc_pkg::TERM_I: n_term = tfpc_pkg::TERM_D;
                    default: begin
                        n_term = tfpc_pkg::TERM_P;
                        n_dimm = 1'b1;
                        if (r_dimm) begin
                            n_state = S_DRAIN;
                        end
                    end
                endcase
            end
            S_DRAIN: begin
                n_state = S_SPD;
            end
            S_SPD: begin
                o_cmd.spd = 1'b1;
                n_state   = S_FAN;
            end
            S_FAN: begin
                o_cmd.fan = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tfpc_datapath.sv @@
// Datapath of the thermal fan controller: config, error memory, PID math, result register.
`timescale 1ns / 1ps

module tfpc_datapath #(
    parameter int WINDOW = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [tfpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tfpc_pkg::GAIN_W-1:0]          i_cfg_data,
    input  logic                                 i_power_on,
    input  logic [tfpc_pkg::TEMP_W-1:0]          i_cpu_temp,
    input  logic [tfpc_pkg::TEMP_W-1:0]          i_dimm_temp,
    input  logic [tfpc_pkg::TEMP_W-1:0]          i_ambient_temp,
    input  logic [tfpc_pkg::TACH_W-1:0]          i_tach_zero,
    input  logic                                 i_ready,
    input  tfpc_pkg::t_cmd                       i_cmd,
    output tfpc_pkg::t_status                    o_status,
    output logic                                 o_valid,
    output logic [7:0]                           o_pwm_duty,
    output logic [7:0]                           o_led_port0,
    output logic [7:0]                           o_led_port1,
    output logic [tfpc_pkg::MOD_W-1:0]           o_fan_present,
    output logic [tfpc_pkg::MOD_W-1:0]           o_presence_changed
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = tfpc_pkg::ERR_W + $clog2(WINDOW);
    localparam int EW = tfpc_pkg::ERR_W;
    localparam int GW = tfpc_pkg::GAIN_W;
    localparam int TW = tfpc_pkg::TEMP_W;
    localparam int QW = tfpc_pkg::PROD_W;
    localparam int MW = tfpc_pkg::MOD_W;
    localparam int CW = tfpc_pkg::PCT_W;

    // configuration
    logic signed [GW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [TW-1:0] r_cpu_tgt, r_dimm_tgt, r_warn, r_amb_low, r_amb_high;

    // captured beat
    logic          r_power;
    logic [TW-1:0] r_cpu, r_dimm, r_amb;
    logic [tfpc_pkg::TACH_W-1:0] r_tz;
    logic signed [EW-1:0] r_err_c, r_err_d;

    // PID state
    logic [2*EW-1:0]      r_mem [WINDOW];
    logic [WINDOW-1:0]    r_ent_vld;
    logic [2*EW-1:0]      r_rd_data;
    logic                 r_rd_vld;
    logic [PW-1:0]        r_pos;
    logic signed [SW-1:0] r_sum_c, r_sum_d;
    logic signed [EW-1:0] r_prev_c, r_prev_d;
    logic [CW-1:0]        r_fp;

    // multiply and accumulate
    logic signed [QW-1:0] r_prod, r_acc_c, r_acc_d;
    logic                 r_prod_vld, r_prod_dimm;
    logic [CW-1:0]        r_spd_c, r_spd_d;

    // result register
    logic          r_out_vld;
    logic [7:0]    r_pwm, r_p0, r_p1;
    logic [MW-1:0] r_present, r_changed, r_prev_presence;

    logic signed [EW-1:0] old_c, old_d, n_err_c, n_err_d;
    logic signed [EW:0]   diff;
    logic signed [GW-1:0] mul_a, mul_b;
    logic [TW-1:0]        amb_adj;
    logic [TW:0]          amb_dbl;
    logic [CW-1:0]        open_pct, closed_pct, n_fp;
    logic [7:0]           n_pwm, n_p0, n_p1;
    logic [MW-1:0]        n_present;
    logic [tfpc_pkg::TACH_W-1:0] tz_used;
    logic                 pid_run;

    function automatic logic [CW-1:0] chan_pct(input logic signed [QW-1:0] acc,
                                               input logic [CW-1:0] fp);
        logic signed [QW-1:0] rnd;
        logic signed [19:0]   quo;
        logic signed [20:0]   spd;
        // truncate toward zero: bias negative values before the shift
        rnd = acc + (acc[QW-1] ? 32'sd4095 : 32'sd0);
        quo = 20'(rnd >>> 12);
        spd = 21'(quo) + $signed({14'b0, fp});
        if (spd > $signed({14'b0, tfpc_pkg::PCT_FULL})) begin
            return tfpc_pkg::PCT_FULL;
        end else if (spd < 21'sd0) begin
            return '0;
        end
        return spd[CW-1:0];
    endfunction

    assign pid_run  = r_power && (r_cpu != '0) && (r_amb != '0);
    assign o_status.pid_run  = pid_run;
    assign o_status.out_free = !r_out_vld || i_ready;

    assign n_err_c = $signed(EW'({1'b0, i_cpu_temp}) - EW'({1'b0, r_cpu_tgt}));
    assign n_err_d = $signed(EW'({1'b0, i_dimm_temp}) - EW'({1'b0, r_dimm_tgt}));

    assign old_c = r_rd_vld ? $signed(r_rd_data[2*EW-1:EW]) : '0;
    assign old_d = r_rd_vld ? $signed(r_rd_data[EW-1:0]) : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= tfpc_pkg::RST_GAIN_PROP;
            r_gain_i   <= tfpc_pkg::RST_GAIN_INTEG;
            r_gain_d   <= tfpc_pkg::RST_GAIN_DERIV;
            r_cpu_tgt  <= tfpc_pkg::RST_CPU_TARGET;
            r_dimm_tgt <= tfpc_pkg::RST_DIMM_TARGET;
            r_warn     <= tfpc_pkg::RST_WARN_LIMIT;
            r_amb_low  <= tfpc_pkg::RST_AMB_LOW;
            r_amb_high <= tfpc_pkg::RST_AMB_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tfpc_pkg::CFG_GAIN_PROP:   r_gain_p   <= i_cfg_data;
                tfpc_pkg::CFG_GAIN_INTEG:  r_gain_i   <= i_cfg_data;
                tfpc_pkg::CFG_GAIN_DERIV:  r_gain_d   <= i_cfg_data;
                tfpc_pkg::CFG_CPU_TARGET:  r_cpu_tgt  <= i_cfg_data[TW-1:0];
                tfpc_pkg::CFG_DIMM_TARGET: r_dimm_tgt <= i_cfg_data[TW-1:0];
                tfpc_pkg::CFG_WARN_LIMIT:  r_warn     <= i_cfg_data[TW-1:0];
                tfpc_pkg::CFG_AMB_LOW:     r_amb_low  <= i_cfg_data[TW-1:0];
                tfpc_pkg::CFG_AMB_HIGH:    r_amb_high <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // capture beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_power <= i_power_on;
            r_cpu   <= i_cpu_temp;
            r_dimm  <= i_dimm_temp;
            r_amb   <= i_ambient_temp;
            r_tz    <= i_tach_zero;
            r_err_c <= n_err_c;
            r_err_d <= n_err_d;
        end
    end

    // error memory, both channels side by side
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_pos];
        end
        if (i_cmd.sum_upd) begin
            r_mem[r_pos] <= {r_err_c, r_err_d};
        end
    end

    // PID history: entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_pos     <= '0;
            r_sum_c   <= '0;
            r_sum_d   <= '0;
            r_prev_c  <= '0;
            r_prev_d  <= '0;
            r_fp      <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_vld <= r_ent_vld[r_pos];
            end
            if (i_cmd.sum_upd) begin
                r_ent_vld[r_pos] <= 1'b1;
                r_sum_c <= r_sum_c - SW'(old_c) + SW'(r_err_c);
                r_sum_d <= r_sum_d - SW'(old_d) + SW'(r_err_d);
            end
            if (i_cmd.fan) begin
                r_fp     <= n_fp;
                r_prev_c <= r_err_c;
                r_prev_d <= r_err_d;
                if (r_pos == PW'(WINDOW - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        diff = i_cmd.mul_dimm ? (EW+1)'(r_err_d) - (EW+1)'(r_prev_d)
                              : (EW+1)'(r_err_c) - (EW+1)'(r_prev_c);
        case (i_cmd.mul_term)
            tfpc_pkg::TERM_P: begin
                mul_a = r_gain_p;
                mul_b = i_cmd.mul_dimm ? GW'(r_err_d) : GW'(r_err_c);
            end
            tfpc_pkg::TERM_I: begin
                mul_a = r_gain_i;
                mul_b = i_cmd.mul_dimm ? GW'(r_sum_d) : GW'(r_sum_c);
            end
            default: begin
                mul_a = r_gain_d;
                mul_b = GW'(diff);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= QW'(mul_a) * QW'(mul_b);
        r_prod_dimm <= i_cmd.mul_dimm;
        if (i_cmd.load) begin
            r_acc_c <= '0;
            r_acc_d <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_dimm) begin
                r_acc_d <= r_acc_d + r_prod;
            end else begin
                r_acc_c <= r_acc_c + r_prod;
            end
        end
        if (i_cmd.spd) begin
            r_spd_c <= chan_pct(r_acc_c, r_fp);
            r_spd_d <= chan_pct(r_acc_d, r_fp);
        end
    end

    // closed loop, open-loop ambient ramp, new fan percent
    always_comb begin
        amb_adj = r_amb - TW'(1);
        amb_dbl = {amb_adj, 1'b0};
        if (amb_adj >= r_amb_high) begin
            open_pct = tfpc_pkg::PCT_FULL;
        end else if (amb_adj <= r_amb_low) begin
            open_pct = tfpc_pkg::PCT_OPEN_MIN;
        end else if (amb_dbl > (TW+1)'(tfpc_pkg::PCT_FULL)) begin
            open_pct = tfpc_pkg::PCT_FULL;
        end else if (amb_dbl < (TW+1)'(tfpc_pkg::PCT_OPEN_MIN)) begin
            open_pct = tfpc_pkg::PCT_OPEN_MIN;
        end else begin
            open_pct = amb_dbl[CW-1:0];
        end
        if (r_cpu >= r_warn || r_dimm >= r_warn) begin
            closed_pct = tfpc_pkg::PCT_FULL;
        end else begin
            closed_pct = (r_spd_d > r_spd_c) ? r_spd_d : r_spd_c;
        end
        n_fp = (open_pct > closed_pct) ? open_pct : closed_pct;
    end

    // result: PWM, LED bytes, presence
    always_comb begin
        tz_used   = r_tz & tfpc_pkg::TACH_MASK;
        n_present = '0;
        if (!r_power) begin
            n_pwm = tfpc_pkg::PWM_FULL;
            n_p0  = tfpc_pkg::LED_OFF;
            n_p1  = tfpc_pkg::LED_OFF;
        end else begin
            if (pid_run) begin
                n_pwm = tfpc_pkg::pct_to_pwm(r_fp);
                if (r_fp > tfpc_pkg::PCT_BLUE_MIN) begin
                    n_p0 = tfpc_pkg::LED_BLUE0;
                    n_p1 = tfpc_pkg::LED_BLUE1;
                end else begin
                    n_p0 = tfpc_pkg::LED_RED0;
                    n_p1 = tfpc_pkg::LED_RED1;
                end
            end else begin
                n_pwm = tfpc_pkg::PWM_FULL;
                n_p0  = tfpc_pkg::LED_BLUE0;
                n_p1  = tfpc_pkg::LED_BLUE1;
            end
            for (int m = 0; m < MW; m++) begin
                n_present[m] = (tfpc_pkg::TACH_MASK[2*m]   && !r_tz[2*m])
                            || (tfpc_pkg::TACH_MASK[2*m+1] && !r_tz[2*m+1]);
                if (tz_used[2*m] || tz_used[2*m+1]) begin
                    n_pwm = tfpc_pkg::PWM_FULL;
                end
            end
            // first two modules flag on port 1, the rest on port 0
            for (int m = 0; m < 2; m++) begin
                if (tz_used[2*m] || tz_used[2*m+1]) begin
                    n_p1[7-2*m] = 1'b1;
                    n_p1[6-2*m] = 1'b0;
                end
            end
            for (int m = 2; m < MW; m++) begin
                if (tz_used[2*m] || tz_used[2*m+1]) begin
                    n_p0[2*(m-2)]   = 1'b1;
                    n_p0[2*(m-2)+1] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld       <= 1'b0;
            r_prev_presence <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_vld       <= 1'b1;
                r_prev_presence <= n_present;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pwm     <= n_pwm;
            r_p0      <= n_p0;
            r_p1      <= n_p1;
            r_present <= n_present;
            r_changed <= n_present ^ r_prev_presence;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_pwm_duty         = r_pwm;
    assign o_led_port0        = r_p0;
    assign o_led_port1        = r_p1;
    assign o_fan_present      = r_present;
    assign o_presence_changed = r_changed;

endmodule

@@ hw/rtl/thermal_fan_pid_controller_unit.sv @@
// Top level of the thermal fan PID controller: sequencer plus datapath.
`timescale 1ns / 1ps

// One input beat is one control period. With power on and nonzero CPU and
// ambient readings, two incremental PID channels (CPU and DIMM) run on a
// WINDOW-deep error history; the result is the larger of the closed-loop
// percent (forced to 100 at the warning limit) and an ambient ramp, shown
// as PWM duty, LED expander bytes and fan presence with change marks.
// Sequence: a period with the PID running steps from input accept through
// memory read, window-sum update, the six P, I and D products (formed one
// per cycle by a single 16x16 signed multiplier), drain, percent and
// fan-update steps to the result being loaded into the output register.
// Power-off and missing-reading periods jump from read to load. A new input
// beat is taken in the cycle after the result is loaded, while that result
// may still wait in the output register for the consumer. The window sum is
// kept as a running total (new error in, overwritten error out), so no pass
// over the history is needed. History entries carry valid bits cleared at
// reset and read as zero until written: no clearing pass after reset.
// Configuration writes are always ready and must be done while idle.
module thermal_fan_pid_controller_unit #(
    parameter int WINDOW = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfpc_pkg::GAIN_W-1:0]     i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_power_on,
    input  logic [tfpc_pkg::TEMP_W-1:0]     i_cpu_temp,
    input  logic [tfpc_pkg::TEMP_W-1:0]     i_dimm_temp,
    input  logic [tfpc_pkg::TEMP_W-1:0]     i_ambient_temp,
    input  logic [tfpc_pkg::TACH_W-1:0]     i_tach_zero,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_pwm_duty,
    output logic [7:0]                      o_led_port0,
    output logic [7:0]                      o_led_port1,
    output logic [tfpc_pkg::MOD_W-1:0]      o_fan_present,
    output logic [tfpc_pkg::MOD_W-1:0]      o_presence_changed
);

    tfpc_pkg::t_cmd    cmd;
    tfpc_pkg::t_status status;

    // Registers take every write beat at once.
    assign o_cfg_ready = 1'b1;

    // Sequencer: takes the input beat and steps the datapath.
    tfpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: config registers, error history, multiplier, result register.
    tfpc_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_power_on         (i_power_on),
        .i_cpu_temp         (i_cpu_temp),
        .i_dimm_temp        (i_dimm_temp),
        .i_ambient_temp     (i_ambient_temp),
        .i_tach_zero        (i_tach_zero),
        .i_ready            (i_ready),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_valid            (o_valid),
        .o_pwm_duty         (o_pwm_duty),
        .o_led_port0        (o_led_port0),
        .o_led_port1        (o_led_port1),
        .o_fan_present      (o_fan_present),
        .o_presence_changed (o_presence_changed)
    );

endmodule
